@@ hw/rtl/wpm_pkg.sv @@
`timescale 1ns / 1ps

package wpm_pkg;

  // Pattern geometry
  localparam int PATTERN_MAX = 16;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int REG_IDX_W   = 3;

  // Register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_PAT_LO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HI  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LENGTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WILD    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANY_ONE = 3'd4;

  // Reset values: star and question mark
  localparam logic [CHAR_W-1:0] WILD_RESET    = 8'd42;
  localparam logic [CHAR_W-1:0] ANY_ONE_RESET = 8'd63;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;

  // Configuration as seen by the matching logic
  typedef struct packed {
    char_t [PATTERN_MAX-1:0] pattern;
    logic  [LEN_W-1:0]       len_used;
    char_t                   wild;
    char_t                   any_one;
  } cfg_t;

  // Wildcard closure as a parallel prefix: bit i is set if some bit j <= i
  // is set in g_in and every bit from j+1 to i propagates.
  function automatic pos_t wpm_closure(pos_t g_in, pos_t p_in);
    pos_t g;
    pos_t p;
    g = g_in;
    p = p_in;
    for (int k = 1; k < POS_W; k = k * 2) begin
      g = g | (p & (g << k));
      p = p & (p << k);
    end
    return g;
  endfunction

endpackage

@@ hw/rtl/wpm_cfg_regs.sv @@
`timescale 1ns / 1ps

module wpm_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wpm_pkg::DATA_W-1:0]  pwdata,
  output logic [wpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output wpm_pkg::cfg_t               cfg,
  output logic                        cfg_wr
);

  logic [wpm_pkg::DATA_W-1:0]    pat_lo_r;
  logic [wpm_pkg::DATA_W-1:0]    pat_hi_r;
  logic [wpm_pkg::LEN_W-1:0]     length_r;
  wpm_pkg::char_t                wild_r;
  wpm_pkg::char_t                any_one_r;
  logic [wpm_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[wpm_pkg::ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      length_r  <= '0;
      wild_r    <= wpm_pkg::WILD_RESET;
      any_one_r <= wpm_pkg::ANY_ONE_RESET;
    end else if (wr_en) begin
      case (idx)
        wpm_pkg::REG_PAT_LO:  pat_lo_r  <= pwdata;
        wpm_pkg::REG_PAT_HI:  pat_hi_r  <= pwdata;
        wpm_pkg::REG_LENGTH:  length_r  <= pwdata[wpm_pkg::LEN_W-1:0];
        wpm_pkg::REG_WILD:    wild_r    <= pwdata[wpm_pkg::CHAR_W-1:0];
        wpm_pkg::REG_ANY_ONE: any_one_r <= pwdata[wpm_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Any write to a defined register restarts the matcher
  always_comb begin
    case (idx)
      wpm_pkg::REG_PAT_LO,
      wpm_pkg::REG_PAT_HI,
      wpm_pkg::REG_LENGTH,
      wpm_pkg::REG_WILD,
      wpm_pkg::REG_ANY_ONE: cfg_wr = wr_en;
      default:              cfg_wr = 1'b0;
    endcase
  end

  // Read back
  always_comb begin
    case (idx)
      wpm_pkg::REG_PAT_LO:  prdata = pat_lo_r;
      wpm_pkg::REG_PAT_HI:  prdata = pat_hi_r;
      wpm_pkg::REG_LENGTH:  prdata = {{(wpm_pkg::DATA_W-wpm_pkg::LEN_W){1'b0}}, length_r};
      wpm_pkg::REG_WILD:    prdata = {{(wpm_pkg::DATA_W-wpm_pkg::CHAR_W){1'b0}}, wild_r};
      wpm_pkg::REG_ANY_ONE: prdata = {{(wpm_pkg::DATA_W-wpm_pkg::CHAR_W){1'b0}}, any_one_r};
      default:              prdata = '0;
    endcase
  end

  // Matching view: byte array plus length clamped to the pattern size
  always_comb begin
    cfg.pattern = {pat_hi_r, pat_lo_r};
    cfg.wild    = wild_r;
    cfg.any_one = any_one_r;
    if (length_r > wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX)) begin
      cfg.len_used = wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX);
    end else begin
      cfg.len_used = length_r;
    end
  end

endmodule

@@ hw/rtl/wpm_nfa.sv @@
`timescale 1ns / 1ps

module wpm_nfa (
  input  logic           clk,
  input  logic           rst_n,
  input  wpm_pkg::cfg_t  cfg,
  input  logic           cfg_wr,
  input  logic           step_en,
  input  wpm_pkg::char_t char_value,
  input  logic           char_valid,
  input  logic           last,
  output logic           matched
);

  wpm_pkg::pos_t active_r;
  wpm_pkg::pos_t active_nxt;
  logic          restart_r;
  logic          restart_nxt;

  wpm_pkg::pos_t prop;
  wpm_pkg::pos_t start_vec;
  wpm_pkg::pos_t cur_vec;
  wpm_pkg::pos_t step_vec;
  wpm_pkg::pos_t upd_vec;
  logic [wpm_pkg::PATTERN_MAX-1:0] is_wild;
  logic [wpm_pkg::PATTERN_MAX-1:0] hit;

  // Per-position pattern decode
  always_comb begin
    for (int p = 0; p < wpm_pkg::PATTERN_MAX; p++) begin
      is_wild[p] = (cfg.pattern[p] == cfg.wild) &&
                   (wpm_pkg::LEN_W'(p) < cfg.len_used);
      hit[p]     = (cfg.pattern[p] == cfg.any_one) || (cfg.pattern[p] == char_value);
    end
    prop = {is_wild, 1'b0};
  end

  // Start vector, and current vector (start after a restart)
  assign start_vec = wpm_pkg::wpm_closure(wpm_pkg::pos_t'(1), prop);
  assign cur_vec   = restart_r ? start_vec : active_r;

  // One byte step: a wild position stays, a matching position advances
  always_comb begin
    step_vec = '0;
    for (int p = 0; p < wpm_pkg::PATTERN_MAX; p++) begin
      if (cur_vec[p] && (wpm_pkg::LEN_W'(p) < cfg.len_used)) begin
        if (is_wild[p]) begin
          step_vec[p] = 1'b1;
        end else if (hit[p]) begin
          step_vec[p+1] = 1'b1;
        end
      end
    end
  end

  assign upd_vec = char_valid ? wpm_pkg::wpm_closure(step_vec, prop) : cur_vec;
  assign matched = upd_vec[cfg.len_used];

  // State update
  always_comb begin
    active_nxt  = active_r;
    restart_nxt = restart_r;
    if (cfg_wr) begin
      restart_nxt = 1'b1;
    end else if (step_en) begin
      active_nxt  = upd_vec;
      restart_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= 1'b1;
    end else begin
      restart_r <= restart_nxt;
    end
  end

  always_ff @(posedge clk) begin
    active_r <= active_nxt;
  end

endmodule

@@ hw/rtl/wildcard_pattern_matcher.sv @@
`timescale 1ns / 1ps

// Streaming wildcard matcher. Each transaction on the in_ channel carries one
// byte of a subject string (or, with in_char_valid low, no byte); the
// transaction with in_last high ends the string and gives one out_ transaction
// whose out_matched tells whether the whole string matches the configured
// pattern. The wild byte (reset '*', write '%' for SQL style) matches any run
// including an empty one; the any-one byte (reset '?', or '_') matches one
// byte. A new byte is taken every cycle unless in_stall is high: each byte
// goes through an input register, one parallel update of the 17-bit
// active-position vector, and an output register. in_stall rises only while
// a finished result is held by out_stall and another last byte waits behind
// it. Write configuration only while idle; any write to a defined register
// restarts the current string.
module wildcard_pattern_matcher (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char_value,
  input  logic                        in_char_valid,
  input  logic                        in_last,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_matched,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wpm_pkg::ADDR_W-1:0]  paddr,
  input  logic [wpm_pkg::DATA_W-1:0]  pwdata,
  output logic [wpm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  wpm_pkg::cfg_t  cfg;
  logic           cfg_wr;

  logic           s_valid_r;
  logic           s_valid_nxt;
  wpm_pkg::char_t s_char_r;
  logic           s_cvalid_r;
  logic           s_last_r;
  logic           s_adv;
  logic           in_acc;
  logic           matched;
  logic           out_valid_r;
  logic           out_valid_nxt;
  logic           out_matched_r;

  wpm_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // Input stage moves on unless it holds a last byte and the result is blocked
  assign s_adv    = s_valid_r && (!s_last_r || !out_valid_r || !out_stall);
  assign in_stall = s_valid_r && !s_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_acc) begin
      s_valid_nxt = 1'b1;
    end else if (s_adv) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_char_r   <= in_char_value;
      s_cvalid_r <= in_char_valid;
      s_last_r   <= in_last;
    end
  end

  wpm_nfa u_nfa (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cfg_wr     (cfg_wr),
    .step_en    (s_adv),
    .char_value (s_char_r),
    .char_valid (s_cvalid_r),
    .last       (s_last_r),
    .matched    (matched)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s_adv && s_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_last_r) begin
      out_matched_r <= matched;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

@@ hw/rtl/wpm_checker.sv @@
`timescale 1ns / 1ps

module wpm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_matched,
  input logic                        pready
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched))
    else $error("stalled result changed");

  // Input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A fresh result follows an accepted last byte via the input and result registers
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last, 2))
    else $error("result without a last byte");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_last     (in_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_matched (out_matched),
  .pready      (pready)
);

@@ tb/match_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and register traffic around the matcher, keeps its
// own copy of the pattern and of the active-position vector, and checks each
// result transaction against the oldest predicted match bit.
module match_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [7:0]                 in_char_value,
  input  logic                       in_char_valid,
  input  logic                       in_last,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_matched,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [wpm_pkg::ADDR_W-1:0] paddr,
  input  logic [wpm_pkg::DATA_W-1:0] pwdata,
  output int                         mismatch_count,
  output int                         results_owed
);

  // Shadow configuration
  wpm_pkg::char_t             pat_q [wpm_pkg::PATTERN_MAX];
  logic [wpm_pkg::LEN_W-1:0]  len_q;
  wpm_pkg::char_t             wild_q;
  wpm_pkg::char_t             any_q;

  // Active pattern positions of the string in progress
  wpm_pkg::pos_t              live_pos;
  logic                       expected_matches [$];
  int                         errs = 0;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // Pattern bytes in use; lengths past the maximum saturate
  function automatic int span();
    return (len_q > wpm_pkg::PATTERN_MAX) ? wpm_pkg::PATTERN_MAX : int'(len_q);
  endfunction

  // A live wild byte also makes the next position live, chaining forward
  function automatic wpm_pkg::pos_t close_wild(wpm_pkg::pos_t v);
    wpm_pkg::pos_t r;
    r = v;
    for (int p = 0; p < span(); p++)
      if (r[p] && pat_q[p] == wild_q) r[p+1] = 1'b1;
    return r;
  endfunction

  // One subject byte: wild stays put, any-one or equal literal moves on
  function automatic wpm_pkg::pos_t advance(wpm_pkg::pos_t v, wpm_pkg::char_t c);
    wpm_pkg::pos_t nxt;
    nxt = '0;
    for (int p = 0; p < span(); p++) begin
      if (v[p]) begin
        if (pat_q[p] == wild_q) nxt[p] = 1'b1;
        else if (pat_q[p] == any_q || pat_q[p] == c) nxt[p+1] = 1'b1;
      end
    end
    return close_wild(nxt);
  endfunction

  always @(posedge clk) begin : track
    logic                          want;
    logic                          hit;
    logic [wpm_pkg::REG_IDX_W-1:0] reg_idx;
    if (!rst_n) begin
      foreach (pat_q[b]) pat_q[b] = '0;
      len_q    = '0;
      wild_q   = wpm_pkg::WILD_RESET;
      any_q    = wpm_pkg::ANY_ONE_RESET;
      live_pos = close_wild(wpm_pkg::pos_t'(1));
      expected_matches.delete();
    end else begin
      // Register write: update the shadow copy and restart the string
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[wpm_pkg::ADDR_W-1:3];
        hit = 1'b1;
        case (reg_idx)
          wpm_pkg::REG_PAT_LO:
            for (int b = 0; b < 8; b++) pat_q[b] = pwdata[8*b +: 8];
          wpm_pkg::REG_PAT_HI:
            for (int b = 0; b < 8; b++) pat_q[b+8] = pwdata[8*b +: 8];
          wpm_pkg::REG_LENGTH:  len_q = pwdata[wpm_pkg::LEN_W-1:0];
          wpm_pkg::REG_WILD:    wild_q = pwdata[wpm_pkg::CHAR_W-1:0];
          wpm_pkg::REG_ANY_ONE: any_q = pwdata[wpm_pkg::CHAR_W-1:0];
          default:              hit = 1'b0;
        endcase
        if (hit) live_pos = close_wild(wpm_pkg::pos_t'(1));
      end

      // Accepted item: byteless items leave the vector alone
      if (in_valid && !in_stall) begin
        if (in_char_valid) live_pos = advance(live_pos, in_char_value);
        if (in_last) begin
          expected_matches.push_back(live_pos[span()]);
          live_pos = close_wild(wpm_pkg::pos_t'(1));
        end
      end

      // Accepted result: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_matches.size() == 0) begin
          $error("unexpected result transaction: matched actual %0b, none expected",
                 out_matched);
          errs++;
        end else begin
          want = expected_matches.pop_front();
          if (out_matched !== want) begin
            $error("field matched: expected %0b, actual %0b", want, out_matched);
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    results_owed   <= expected_matches.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the wildcard matcher; all checking sits in the
// checker instances next to the block.
module tb_top;

  localparam int             PHASES       = 14;
  localparam int             PHASE_ITEMS  = 105;
  localparam int             DRAIN_CYCLES = 8;
  localparam int unsigned    CYCLE_LIMIT  = 400000;
  localparam wpm_pkg::char_t PCT          = "%";
  localparam wpm_pkg::char_t USCORE       = "_";

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_stall;
  logic [7:0]                   in_char_value = '0;
  logic                         in_char_valid = 1'b0;
  logic                         in_last       = 1'b0;
  logic                         out_valid;
  logic                         out_stall     = 1'b0;
  logic                         out_matched;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [wpm_pkg::ADDR_W-1:0]   paddr         = '0;
  logic [wpm_pkg::DATA_W-1:0]   pwdata        = '0;
  logic [wpm_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  int                           mismatch_count;
  int                           results_owed;

  // Stimulus state
  wpm_pkg::char_t               pat_bytes [wpm_pkg::PATTERN_MAX];
  wpm_pkg::char_t               cur_wild;
  wpm_pkg::char_t               cur_any;
  int                           items_sent  = 0;
  int                           burst_left  = 0;
  int                           stall_run   = 0;
  int unsigned                  cycle_count = 0;

  wildcard_pattern_matcher dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_value (in_char_value),
    .in_char_valid (in_char_valid),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_matched   (out_matched),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  match_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_value  (in_char_value),
    .in_char_valid  (in_char_valid),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_matched    (out_matched),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #6 clk = ~clk;

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result-side backpressure: short flickers, long holds and quiet stretches
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_run == 0) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(1, 6);
      end else if (r < 7) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(1, 3);
      end else if (r < 9) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(20, 120);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(8, 16);
      end
    end else begin
      stall_run--;
    end
  end

  // Register write: setup cycle, access cycle, then back to idle with psel low
  task automatic cfg_write(input logic [wpm_pkg::REG_IDX_W-1:0] idx,
                           input logic [wpm_pkg::DATA_W-1:0]    data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Program the pattern bytes, length and both wildcard bytes
  task automatic load_config(input logic [wpm_pkg::LEN_W-1:0] len);
    logic [wpm_pkg::DATA_W-1:0] lo;
    logic [wpm_pkg::DATA_W-1:0] hi;
    for (int b = 0; b < 8; b++) begin
      lo[8*b +: 8] = pat_bytes[b];
      hi[8*b +: 8] = pat_bytes[b+8];
    end
    cfg_write(wpm_pkg::REG_PAT_LO, lo);
    cfg_write(wpm_pkg::REG_PAT_HI, hi);
    cfg_write(wpm_pkg::REG_LENGTH, wpm_pkg::DATA_W'(len));
    cfg_write(wpm_pkg::REG_WILD, wpm_pkg::DATA_W'(cur_wild));
    cfg_write(wpm_pkg::REG_ANY_ONE, wpm_pkg::DATA_W'(cur_any));
  endtask

  // One input transaction; the sender runs in bursts with random gaps
  task automatic send_item(input wpm_pkg::char_t c, input logic cv, input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_char_value <= c;
    in_char_valid <= cv;
    in_last       <= lst;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // Stop sending and hold off until every result is back and the pipe is empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a small alphabet so literals line up; the rest full range
  function automatic wpm_pkg::char_t subject_byte(input logic noisy);
    if (noisy || $urandom_range(0, 9) < 3) return wpm_pkg::char_t'($urandom_range(0, 255));
    return wpm_pkg::char_t'(8'h61 + $urandom_range(0, 2));
  endfunction

  function automatic wpm_pkg::char_t pattern_char(input logic noisy);
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return cur_wild;
    if (r < 8) return cur_any;
    return subject_byte(noisy);
  endfunction

  // Build a string that fits the pattern, break a third of them, and send it
  task automatic send_string(input int used, input logic noisy);
    wpm_pkg::char_t s [$];
    int             idx;
    logic           tail_empty;
    for (int p = 0; p < used; p++) begin
      if (pat_bytes[p] == cur_wild) begin
        repeat ($urandom_range(0, 3)) s.push_back(subject_byte(noisy));
      end else if (pat_bytes[p] == cur_any) begin
        s.push_back(subject_byte(noisy));
      end else begin
        s.push_back(pat_bytes[p]);
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      idx = (s.size() > 0) ? $urandom_range(0, s.size() - 1) : 0;
      case ($urandom_range(0, 3))
        0: if (s.size() > 0) s[idx] = subject_byte(noisy);
        1: if (s.size() > 0) s.delete(idx);
        2: s.insert(idx, subject_byte(noisy));
        default: s.push_back(subject_byte(noisy));
      endcase
    end
    // Sometimes close the string with a byteless last transaction
    tail_empty = (s.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (s[i]) begin
      if ($urandom_range(0, 9) == 0) send_item(subject_byte(1'b1), 1'b0, 1'b0);
      send_item(s[i], 1'b1, (i == s.size() - 1) && !tail_empty);
    end
    if (tail_empty) send_item(subject_byte(1'b1), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    logic                      noisy;
    logic                      full_noise;
    logic [wpm_pkg::LEN_W-1:0] len;
    int                        used;
    int                        phase_goal;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration, empty pattern: only the empty string matches
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    wait_idle();

    // Lone star: matches the empty string through closure at restart
    foreach (pat_bytes[b]) pat_bytes[b] = 8'h00;
    cur_wild     = wpm_pkg::WILD_RESET;
    cur_any      = wpm_pkg::ANY_ONE_RESET;
    pat_bytes[0] = wpm_pkg::WILD_RESET;
    load_config(5'd1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item("x", 1'b1, 1'b1);
    wait_idle();

    // a*?c: match, short miss, and a byteless transaction mid-string
    pat_bytes[0] = "a";
    pat_bytes[1] = wpm_pkg::WILD_RESET;
    pat_bytes[2] = wpm_pkg::ANY_ONE_RESET;
    pat_bytes[3] = "c";
    load_config(5'd4);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item("a", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item("a", 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item("x", 1'b1, 1'b0);
    send_item("y", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    wait_idle();

    // Random phases, each under its own pattern setting
    for (int ph = 0; ph < PHASES; ph++) begin
      noisy      = 1'b0;
      full_noise = 1'b0;
      cur_wild   = wpm_pkg::WILD_RESET;
      cur_any    = wpm_pkg::ANY_ONE_RESET;
      len        = wpm_pkg::LEN_W'($urandom_range(1, wpm_pkg::PATTERN_MAX));
      case (ph)
        1, 8, 12: begin
          cur_wild = PCT;
          cur_any  = USCORE;
        end
        2:  len = 5'd16;
        3:  len = 5'd31;
        4:  len = 5'd0;
        5:  cur_any = wpm_pkg::WILD_RESET;
        6: begin
          cur_wild = 8'h00;
          cur_any  = 8'hFF;
          noisy    = 1'b1;
        end
        9: begin
          cur_wild = 8'hFF;
          cur_any  = 8'h00;
          noisy    = 1'b1;
        end
        10: begin
          cur_wild = PCT;
          cur_any  = PCT;
        end
        11: begin
          cur_wild = wpm_pkg::char_t'($urandom_range(0, 255));
          cur_any  = wpm_pkg::char_t'($urandom_range(0, 255));
          noisy    = 1'b1;
          len      = 5'd17;
        end
        13: begin
          cur_wild   = wpm_pkg::char_t'($urandom_range(0, 255));
          cur_any    = wpm_pkg::char_t'($urandom_range(0, 255));
          noisy      = 1'b1;
          full_noise = 1'b1;
          len        = wpm_pkg::LEN_W'($urandom_range(0, 31));
        end
        default: ;
      endcase
      if (ph == 12) len = 5'd16;
      foreach (pat_bytes[b])
        pat_bytes[b] = full_noise ? wpm_pkg::char_t'($urandom_range(0, 255))
                                  : pattern_char(noisy);
      load_config(len);

      used       = (len > wpm_pkg::PATTERN_MAX) ? wpm_pkg::PATTERN_MAX : int'(len);
      phase_goal = items_sent + PHASE_ITEMS;
      while (items_sent < phase_goal) begin
        send_string(used, noisy);
        if ($urandom_range(0, 7) == 0) wait_idle();
      end

      // Leave a string unfinished; the next register write must restart it
      if (ph % 2 == 1) begin
        repeat ($urandom_range(1, 3)) send_item(subject_byte(noisy), 1'b1, 1'b0);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ wildcard_pattern_matcher.f @@
hw/rtl/wpm_pkg.sv
hw/rtl/wpm_cfg_regs.sv
hw/rtl/wpm_nfa.sv
hw/rtl/wildcard_pattern_matcher.sv
hw/rtl/wpm_checker.sv
tb/match_checker.sv
tb/tb_top.sv
